// ===== hdl/raht_pkg.sv =====
package raht_pkg;

    // payload widths of the channels
    localparam int ACTION_W = 2;
    localparam int ADDR_W   = 64;
    localparam int REF_W    = 16;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 10;
    localparam int CFG_W    = 4;

    // table size register lower limit and reset value
    localparam int MIN_LOG2  = 2;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd10;

    // home slot is taken from the key above the word alignment bits
    localparam int HASH_SHIFT = 2;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;      // latch a new word and set up the probe
        logic probe;     // probe sequence running
        logic sweep;     // clearing pass, one slot a cycle
        logic res_zero;  // pending result is ok with zero fields
        logic out_load;  // move pending result to the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic decided;     // probe sequence reached its result
        logic sweep_last;  // clearing pass at its last slot
    } t_stat;

endpackage

// ===== hdl/raht_in_if.sv =====
interface raht_in_if;
    logic                           valid;
    logic                           ready;
    logic [raht_pkg::ACTION_W-1:0]  action;
    logic [raht_pkg::ADDR_W-1:0]    return_address;
    logic [raht_pkg::REF_W-1:0]     descriptor_ref;

    modport source (output valid, action, return_address, descriptor_ref, input ready);
    modport sink   (input valid, action, return_address, descriptor_ref, output ready);
endinterface

// ===== hdl/raht_out_if.sv =====
interface raht_out_if;
    logic                           valid;
    logic                           ready;
    logic [raht_pkg::STATUS_W-1:0]  status;
    logic [raht_pkg::REF_W-1:0]     found_ref;
    logic [raht_pkg::SLOT_W-1:0]    slot_index;

    modport source (output valid, status, found_ref, slot_index, input ready);
    modport sink   (input valid, status, found_ref, slot_index, output ready);
endinterface

// ===== hdl/raht_dp.sv =====
module raht_dp #(
    parameter int LOG_SLOTS = 10,
    parameter int REF_BITS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [raht_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [raht_pkg::ACTION_W-1:0]   i_action,
    input  logic [raht_pkg::ADDR_W-1:0]     i_return_address,
    input  logic [raht_pkg::REF_W-1:0]      i_descriptor_ref,
    input  raht_pkg::t_cmd                  i_cmd,
    output raht_pkg::t_stat                 o_stat,
    output logic [raht_pkg::STATUS_W-1:0]   o_status,
    output logic [raht_pkg::REF_W-1:0]      o_found_ref,
    output logic [raht_pkg::SLOT_W-1:0]     o_slot_index
);
    import raht_pkg::*;

    localparam int VAL_W  = (REF_BITS < REF_W) ? REF_BITS : REF_W;
    localparam int WORD_W = 1 + ADDR_W + VAL_W;
    localparam int NSLOTS = 1 << LOG_SLOTS;
    localparam int CNT_W  = LOG_SLOTS + 1;
    localparam int LW     = $clog2(LOG_SLOTS + 1);

    // slot store: {valid, key, value}
    logic [WORD_W-1:0]    mem [0:NSLOTS-1];

    logic [CFG_W-1:0]     r_size_log2;
    logic [LOG_SLOTS-1:0] r_sweep;
    logic [LOG_SLOTS-1:0] r_addr;
    logic [LOG_SLOTS-1:0] r_mask;
    logic [LOG_SLOTS-1:0] r_rd_addr;
    logic [WORD_W-1:0]    r_rd_q;
    logic                 r_rd_vld;
    logic [CNT_W-1:0]     r_left;
    logic [ADDR_W-1:0]    r_key;
    logic [VAL_W-1:0]     r_ref;
    logic                 r_is_insert;
    logic [STATUS_W-1:0]  r_res_status;
    logic [REF_W-1:0]     r_res_ref;
    logic [SLOT_W-1:0]    r_res_slot;
    logic [STATUS_W-1:0]  r_out_status;
    logic [REF_W-1:0]     r_out_ref;
    logic [SLOT_W-1:0]    r_out_slot;

    logic [LW-1:0]        act_log2;
    logic [CNT_W-1:0]     count;
    logic [LOG_SLOTS-1:0] mask;
    logic [LOG_SLOTS-1:0] home;
    logic                 rd_valid;
    logic [ADDR_W-1:0]    rd_key;
    logic [VAL_W-1:0]     rd_val;
    logic                 cmp;
    logic                 last;
    logic                 decided;
    logic                 ins_we;
    logic [STATUS_W-1:0]  res_status;
    logic [REF_W-1:0]     res_ref;
    logic [SLOT_W-1:0]    res_slot;
    logic                 we;
    logic [LOG_SLOTS-1:0] wa;
    logic [WORD_W-1:0]    wd;

    // active size, clamped to the minimum and to the store
    always_comb begin
        if (r_size_log2 < CFG_W'(MIN_LOG2)) begin
            act_log2 = LW'(MIN_LOG2);
        end else if (32'(r_size_log2) > LOG_SLOTS) begin
            act_log2 = LW'(LOG_SLOTS);
        end else begin
            act_log2 = LW'(r_size_log2);
        end
    end

    assign count = CNT_W'(1) << act_log2;
    assign mask  = LOG_SLOTS'(count - CNT_W'(1));
    assign home  = i_return_address[HASH_SHIFT +: LOG_SLOTS] & mask;

    // fields of the slot read last cycle
    assign rd_valid = r_rd_q[WORD_W-1];
    assign rd_key   = r_rd_q[VAL_W +: ADDR_W];
    assign rd_val   = r_rd_q[VAL_W-1:0];
    assign cmp      = i_cmd.probe && r_rd_vld;
    assign last     = (r_left == CNT_W'(1));

    // probe decision
    always_comb begin
        decided    = 1'b0;
        ins_we     = 1'b0;
        res_status = ST_OK;
        res_ref    = '0;
        res_slot   = '0;
        if (cmp) begin
            if (r_is_insert) begin
                if (!rd_valid) begin
                    decided  = 1'b1;
                    ins_we   = 1'b1;
                    res_slot = SLOT_W'(r_rd_addr);
                end else if (last) begin
                    decided    = 1'b1;
                    res_status = ST_FULL;
                end
            end else begin
                if (!rd_valid) begin
                    decided    = 1'b1;
                    res_status = ST_MISS;
                end else if (rd_key == r_key) begin
                    decided  = 1'b1;
                    res_ref  = REF_W'(rd_val);
                    res_slot = SLOT_W'(r_rd_addr);
                end else if (last) begin
                    decided    = 1'b1;
                    res_status = ST_MISS;
                end
            end
        end
    end

    // single write port: clearing pass or insert
    assign we = i_cmd.sweep || ins_we;
    assign wa = i_cmd.sweep ? r_sweep : r_rd_addr;
    assign wd = i_cmd.sweep ? WORD_W'(0) : {1'b1, r_key, r_ref};

    // slot store
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd_q    <= mem[r_addr];
        r_rd_addr <= r_addr;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2 <= CFG_RESET;
            r_sweep     <= '0;
            r_rd_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size_log2 <= i_cfg_data;
            end
            if (i_cmd.sweep) begin
                r_sweep <= r_sweep + LOG_SLOTS'(1);
            end
            r_rd_vld <= i_cmd.probe;
        end
    end

    // probe registers and results
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key       <= i_return_address;
            r_ref       <= VAL_W'(i_descriptor_ref);
            r_is_insert <= (i_action == ACT_INSERT);
            r_mask      <= mask;
            r_addr      <= home;
            r_left      <= count;
        end else if (i_cmd.probe) begin
            r_addr <= (r_addr + LOG_SLOTS'(1)) & r_mask;
            if (cmp && !decided) begin
                r_left <= r_left - CNT_W'(1);
            end
        end
        if (i_cmd.res_zero) begin
            r_res_status <= ST_OK;
            r_res_ref    <= '0;
            r_res_slot   <= '0;
        end else if (decided) begin
            r_res_status <= res_status;
            r_res_ref    <= res_ref;
            r_res_slot   <= res_slot;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_ref    <= r_res_ref;
            r_out_slot   <= r_res_slot;
        end
    end

    assign o_stat.decided    = decided;
    assign o_stat.sweep_last = &r_sweep;
    assign o_status          = r_out_status;
    assign o_found_ref       = r_out_ref;
    assign o_slot_index      = r_out_slot;

    // checks
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.sweep && ins_we))
        else $error("clearing pass and insert write collide");

    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmp |-> (r_left != '0))
        else $error("probe count ran out without a result");

    a_sweep_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.sweep && (&r_sweep)) |=> (r_sweep == '0))
        else $error("sweep counter did not wrap after last slot");

endmodule

// ===== hdl/raht_ctrl.sv =====
module raht_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    input  logic [raht_pkg::ACTION_W-1:0]   i_action,
    output logic                            o_req_ready,
    input  logic                            i_rsp_ready,
    output logic                            o_rsp_valid,
    output raht_pkg::t_cmd                  o_cmd,
    input  raht_pkg::t_stat                 i_stat
);
    import raht_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_PROBE,
        S_SWEEP,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;

    assign accept = (r_state == S_IDLE) && i_req_valid;

    // commands
    always_comb begin
        o_cmd.load     = accept;
        o_cmd.probe    = (r_state == S_PROBE);
        o_cmd.sweep    = (r_state == S_INIT) || (r_state == S_SWEEP);
        o_cmd.res_zero = (accept && !(i_action inside {ACT_INSERT, ACT_LOOKUP, ACT_CLEAR}))
                         || ((r_state == S_SWEEP) && i_stat.sweep_last);
        o_cmd.out_load = (r_state == S_DONE) && (!r_out_valid || i_rsp_ready);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (i_stat.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    case (i_action)
                        ACT_INSERT, ACT_LOOKUP: n_state = S_PROBE;
                        ACT_CLEAR:              n_state = S_SWEEP;
                        default:                n_state = S_DONE;
                    endcase
                end
            end
            S_PROBE: begin
                if (i_stat.decided) n_state = S_DONE;
            end
            S_SWEEP: begin
                if (i_stat.sweep_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (o_cmd.out_load) n_state = S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end

    // output word held until taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;

    // checks
    a_decide_in_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.decided |-> (r_state == S_PROBE))
        else $error("probe result outside probe sequence");

    a_clear_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SWEEP) && i_stat.sweep_last) |=> (r_state == S_DONE))
        else $error("clear did not produce a result");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("loaded result not presented");

endmodule

// ===== hdl/return_address_hash_table_top.sv =====
// Open-addressing table that maps 64-bit return addresses to descriptor
// references with linear probing; the home slot is (address >> 2) masked to
// 2^size_log2 slots (size_log2 clamped to 2..LOG_SLOTS). Words are handled one
// at a time: an insert or lookup checks one slot per cycle, as the single slot
// memory read port allows, until it reaches its result, which then passes
// through the result register to the output register to be handed over. A
// clear sweeps the whole store, one slot per cycle. After reset the same
// clearing pass runs over the whole store, during which no word is accepted;
// size_log2 writes are taken at any time and apply to the next accepted word.
module return_address_hash_table_top #(
    parameter int LOG_SLOTS = 10,
    parameter int REF_BITS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [raht_pkg::CFG_W-1:0]  i_cfg_data,
    raht_in_if.sink                     i_req,
    raht_out_if.source                  o_rsp
);
    import raht_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    raht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_action    (i_req.action),
        .o_req_ready (i_req.ready),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // slot store and probe logic
    raht_dp #(
        .LOG_SLOTS (LOG_SLOTS),
        .REF_BITS  (REF_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_action         (i_req.action),
        .i_return_address (i_req.return_address),
        .i_descriptor_ref (i_req.descriptor_ref),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_status         (o_rsp.status),
        .o_found_ref      (o_rsp.found_ref),
        .o_slot_index     (o_rsp.slot_index)
    );

endmodule

// ===== tb/raht_checker.sv =====
module raht_checker #(
    parameter int LOG_SLOTS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [raht_pkg::CFG_W-1:0]  i_cfg_data,
    raht_in_if                          i_req_mon,
    raht_out_if                         i_rsp_mon,
    output int                          o_errors,
    output int                          o_pending
);
    import raht_pkg::*;

    localparam int NSLOTS = 1 << LOG_SLOTS;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [REF_W-1:0]    found_ref;
        logic [SLOT_W-1:0]   slot_index;
    } t_lookup_result;

    // shadow copy of the table and its size register
    bit                   slot_used [NSLOTS];
    logic [ADDR_W-1:0]    slot_addr [NSLOTS];
    logic [REF_W-1:0]     slot_desc [NSLOTS];
    logic [CFG_W-1:0]     size_reg;

    t_lookup_result       pending_results [$];
    int                   err_count;

    // apply one word to the shadow table and return the word it should produce
    function automatic t_lookup_result predict_word(input logic [ACTION_W-1:0] act,
                                                    input logic [ADDR_W-1:0]   addr,
                                                    input logic [REF_W-1:0]    dref);
        t_lookup_result r;
        int unsigned lg;
        int unsigned count;
        int unsigned mask;
        int unsigned h;
        int unsigned n;
        bit stop;
        r.status     = ST_OK;
        r.found_ref  = '0;
        r.slot_index = '0;
        lg = size_reg;
        if (lg < MIN_LOG2) lg = MIN_LOG2;
        if (lg > LOG_SLOTS) lg = LOG_SLOTS;
        count = 1 << lg;
        mask  = count - 1;
        h     = 32'(addr >> HASH_SHIFT) & mask;
        stop  = 1'b0;
        case (act)
            ACT_INSERT: begin
                r.status = ST_FULL;
                for (n = 0; n < count && !stop; n++) begin
                    if (!slot_used[h]) begin
                        slot_used[h]  = 1'b1;
                        slot_addr[h]  = addr;
                        slot_desc[h]  = dref;
                        r.status      = ST_OK;
                        r.slot_index  = h[SLOT_W-1:0];
                        stop          = 1'b1;
                    end else begin
                        h = (h + 1) & mask;
                    end
                end
            end
            ACT_LOOKUP: begin
                r.status = ST_MISS;
                for (n = 0; n < count && !stop; n++) begin
                    if (!slot_used[h]) begin
                        stop = 1'b1;
                    end else if (slot_addr[h] == addr) begin
                        r.status     = ST_OK;
                        r.found_ref  = slot_desc[h];
                        r.slot_index = h[SLOT_W-1:0];
                        stop         = 1'b1;
                    end else begin
                        h = (h + 1) & mask;
                    end
                end
            end
            ACT_CLEAR: begin
                foreach (slot_used[i]) slot_used[i] = 1'b0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t mismatch in %s: expected %0h actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    // track config writes, predict accepted words, check returned words
    always @(posedge i_clk) begin
        t_lookup_result want;
        if (!i_rst_n) begin
            size_reg = CFG_RESET;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            pending_results.delete();
        end else begin
            if (i_cfg_we) size_reg = i_cfg_data;
            if (i_req_mon.valid && i_req_mon.ready) begin
                pending_results.push_back(predict_word(i_req_mon.action,
                                                       i_req_mon.return_address,
                                                       i_req_mon.descriptor_ref));
            end
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t unexpected word: expected none actual status %0h ref %0h slot %0h",
                             $time, i_rsp_mon.status, i_rsp_mon.found_ref,
                             i_rsp_mon.slot_index);
                    err_count++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("status", want.status, i_rsp_mon.status);
                    compare_field("found_ref", want.found_ref, i_rsp_mon.found_ref);
                    compare_field("slot_index", want.slot_index, i_rsp_mon.slot_index);
                end
            end
        end
        o_errors  <= err_count;
        o_pending <= pending_results.size();
    end

endmodule

// ===== tb/tb_return_address_hash_table_top.sv =====
module tb_return_address_hash_table_top;
    import raht_pkg::*;

    localparam int TB_LOG_SLOTS = 10;
    localparam int TB_REF_BITS  = 16;
    localparam int RANDOM_WORDS = 1850;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [CFG_W-1:0]   cfg_data;
    int                 errors;
    int                 pending;

    raht_in_if  req_if ();
    raht_out_if rsp_if ();

    always #5 clk = ~clk;

    return_address_hash_table_top #(
        .LOG_SLOTS (TB_LOG_SLOTS),
        .REF_BITS  (TB_REF_BITS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    raht_checker #(
        .LOG_SLOTS (TB_LOG_SLOTS)
    ) chk (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_req_mon  (req_if),
        .i_rsp_mon  (rsp_if),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // sender burst state and stimulus bookkeeping
    int                 burst_left = 0;
    logic [ADDR_W-1:0]  known_addrs [$];
    int                 fill;
    int                 act_log2;
    bit                 timed_out;

    // offer one word after an optional gap, return once it is taken
    task automatic send_word(input logic [ACTION_W-1:0] act, input logic [ADDR_W-1:0] addr,
                             input logic [REF_W-1:0] dref);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = $urandom_range(10, 30);
                default: gap = $urandom_range(1, 5);
            endcase
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_if.valid          <= 1'b1;
        req_if.action         <= act;
        req_if.return_address <= addr;
        req_if.descriptor_ref <= dref;
        do @(posedge clk); while (!req_if.ready);
    endtask

    // stop offering and wait until every word has come back
    task automatic drain();
        req_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_size(input logic [CFG_W-1:0] v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        act_log2 = (v < MIN_LOG2) ? MIN_LOG2 : (v > TB_LOG_SLOTS) ? TB_LOG_SLOTS : v;
    endtask

    // half the keys crowd a few home slots to build long probe chains
    function automatic logic [ADDR_W-1:0] fresh_addr();
        logic [ADDR_W-1:0] a;
        a = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 1) a[11:2] = 10'($urandom_range(0, 63));
        return a;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_known();
        return known_addrs[$urandom_range(0, known_addrs.size() - 1)];
    endfunction

    task automatic clear_table();
        send_word(ACT_CLEAR, {$urandom, $urandom}, 16'($urandom));
        known_addrs.delete();
        fill = 0;
    endtask

    // one random word; returns 0 for the unused action code
    task automatic random_word(output bit counted);
        int unsigned pick;
        logic [ADDR_W-1:0] a;
        pick    = $urandom_range(0, 99);
        counted = 1'b1;
        if (pick < 3 || (act_log2 >= 6 && fill > (3 << act_log2) / 4)) begin
            clear_table();
        end else if (pick < 5) begin
            send_word(ACT_UNUSED, {$urandom, $urandom}, 16'($urandom));
            counted = 1'b0;
        end else if (pick < 52) begin
            a = (known_addrs.size() > 0 && pick % 10 == 0) ? pick_known() : fresh_addr();
            send_word(ACT_INSERT, a, 16'($urandom));
            known_addrs.push_back(a);
            fill++;
        end else begin
            a = (known_addrs.size() > 0 && $urandom_range(0, 9) < 7) ? pick_known()
                                                                     : fresh_addr();
            send_word(ACT_LOOKUP, a, 16'($urandom));
        end
    endtask

    task automatic run_stimulus();
        logic [CFG_W-1:0] corner_sizes [6] = '{4'd2, 4'd10, 4'd0, 4'd15, 4'd1, 4'd11};
        int words_done;
        int phase;
        int phase_len;
        bit counted;

        // default size: extremes of the fields, duplicate key, collisions
        act_log2 = TB_LOG_SLOTS;
        send_word(ACT_INSERT, 64'h0, 16'h0000);
        send_word(ACT_INSERT, '1, 16'hFFFF);
        send_word(ACT_LOOKUP, 64'h0, 16'h5A5A);
        send_word(ACT_LOOKUP, '1, 16'h0000);
        send_word(ACT_LOOKUP, 64'h1, 16'hFFFF);
        send_word(ACT_INSERT, 64'h0, 16'h1234);
        send_word(ACT_LOOKUP, 64'h0, 16'h0000);
        send_word(ACT_UNUSED, 64'hDEAD_BEEF_0BAD_F00D, 16'hA5A5);
        send_word(ACT_INSERT, 64'h1000, 16'h00FF);
        send_word(ACT_LOOKUP, 64'h1000, 16'h0000);

        // size below range: four slots, fill up, full sweep miss, hidden entry
        set_size(4'd0);
        send_word(ACT_INSERT, 64'hC, 16'h0C0C);
        send_word(ACT_INSERT, 64'h20, 16'h2020);
        send_word(ACT_LOOKUP, 64'h8, 16'h0000);
        send_word(ACT_LOOKUP, 64'h1000, 16'h0000);
        send_word(ACT_LOOKUP, '1, 16'h0000);

        // size above range: hidden entry back in reach, then clear
        set_size(4'd15);
        send_word(ACT_LOOKUP, '1, 16'h0000);
        clear_table();
        send_word(ACT_LOOKUP, 64'h0, 16'h0000);
        send_word(ACT_INSERT, 64'h8000_0000_0000_0003, 16'hFFFF);
        known_addrs.push_back(64'h8000_0000_0000_0003);
        fill = 1;

        // random phases, each at its own table size, entries kept across sizes
        words_done = 0;
        phase      = 0;
        while (words_done < RANDOM_WORDS) begin
            set_size(phase < 6 ? corner_sizes[phase] : 4'($urandom_range(0, 15)));
            phase_len = $urandom_range(60, 200);
            for (int i = 0; i < phase_len && words_done < RANDOM_WORDS; i++) begin
                random_word(counted);
                if (counted) words_done++;
            end
            phase++;
        end
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // receiver: changing stall patterns plus two long hold-offs
    initial begin
        int cyc;
        int mode;
        int mode_left;
        int period;
        int duty;
        int hold_left;
        rsp_if.ready <= 1'b0;
        cyc       = 0;
        mode      = 0;
        mode_left = 0;
        period    = 2;
        duty      = 1;
        hold_left = 0;
        forever begin
            @(posedge clk);
            cyc++;
            if (cyc == 2500 || cyc == 9000) hold_left = 400;
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 150);
                    period    = $urandom_range(2, 6);
                    duty      = $urandom_range(1, period - 1);
                end
                mode_left--;
                case (mode)
                    0:       rsp_if.ready <= 1'b1;
                    1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
                    default: rsp_if.ready <= ((cyc % period) < duty);
                endcase
            end
        end
    end

    // reset, stimulus against the idle watchdog, verdict
    initial begin
        int idle_cycles;
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_data              <= CFG_RESET;
        req_if.valid          <= 1'b0;
        req_if.action         <= ACT_INSERT;
        req_if.return_address <= '0;
        req_if.descriptor_ref <= '0;
        timed_out   = 1'b0;
        idle_cycles = 0;
        fill        = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        fork
            run_stimulus();
            begin
                while (idle_cycles < IDLE_LIMIT) begin
                    @(posedge clk);
                    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                        idle_cycles = 0;
                    else
                        idle_cycles++;
                end
                timed_out = 1'b1;
            end
        join_any
        if (!timed_out && errors == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
